// ===== rtl/catmull_rom_spline_eval_assert.svh =====
// Assertion macros for the spline evaluator.
// Needs clk and rst_n in the scope of the including module.
`ifndef CATMULL_ROM_SPLINE_EVAL_ASSERT_SVH
`define CATMULL_ROM_SPLINE_EVAL_ASSERT_SVH

// clocked check, off during reset
`define CRSE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check, live during reset as well
`define CRSE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/crse_pkg.sv =====
// Package for the Catmull-Rom spline evaluator: sizes, codes, sequencer states.
// No dependencies.
package crse_pkg;

  localparam int MaxNodes = 64;
  localparam int Frac     = 30;

  // command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_EVAL  = 1'b1;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_DEGEN = 2'd2;

  // divider job select
  localparam logic [1:0] DIV_SC0 = 2'd0;
  localparam logic [1:0] DIV_SC1 = 2'd1;
  localparam logic [1:0] DIV_T   = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE, S_LO, S_HI, S_CHK, S_BS, S_BSC, S_CLAMP,
    S_R0, S_R1, S_R2, S_R3, S_R4,
    S_DSET, S_DIT, S_DEND, S_MUL, S_MACC, S_DONE
  } state_t;

endpackage

// ===== rtl/catmull_rom_spline_eval.sv =====
// Catmull-Rom spline evaluator: node table, binary search, divider, Hermite sum.
// A write word is stored while idle. An evaluate word holds busy through the end-node
// range check, the binary table search, the clamp and the reads, three Q.30 divisions
// on the shared bit-serial divider and the Hermite sum on the shared multiplier, and
// then registers the word; out-of-range queries go from the range check to the result.
// The result word comes in the first cycle with busy low, when the next word may already be taken.
module catmull_rom_spline_eval (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_command,
  input  logic [5:0]         in_entry_index,
  input  logic signed [31:0] in_node_position,
  input  logic signed [31:0] in_node_value,
  input  logic signed [31:0] in_query_x,
  output logic               out_valid,
  output logic signed [31:0] out_result_value,
  output logic [1:0]         out_status,
  input  logic               cfg_wr_en,
  input  logic [6:0]         cfg_wr_data
);
  import crse_pkg::*;

  // Reset (rst_n, synchronous, active low) clears control and sets count_r to 64.

  state_t state_r, state_nxt;

  // table: node position in the upper half, value in the lower half
  logic [63:0] mem [0:MaxNodes-1];
  logic [63:0] rdata_r;
  logic [5:0]  ra;
  logic signed [31:0] rd_node, rd_val;

  logic [6:0]  count_r, n_eff;
  logic signed [31:0] x_r;
  logic        oor_r;
  logic [6:0]  first_r, len_r, half, mid;
  logic [5:0]  idx_r;
  logic signed [7:0] idx_s;
  logic        hi_ok;
  logic signed [31:0] x0_r, x1_r, xm_r, xp_r, f0_r, f1_r, fm_r, fp_r;
  logic [1:0]  sel_r, stat_r;
  logic        bad_r;
  logic [30:0] sc0_r, sc1_r, t_r, t2_r, t3_r, q_r;
  logic [34:0] rem_r, rem2;
  logic [33:0] ud_r;
  logic [4:0]  cnt_r;
  logic signed [34:0] d0_r, d1_r;
  logic signed [69:0] prod_r, prod_sh;
  logic signed [71:0] acc_r, acc_sh;
  logic [2:0]  mstep_r;
  logic        out_valid_r;
  logic signed [31:0] out_result_r;
  logic [1:0]  out_status_r;

  // divider job operands
  logic signed [33:0] dnum, dden;
  logic [33:0] un, ud;
  logic        dact;

  // multiplier operands
  logic signed [34:0] ma, mb;
  logic signed [34:0] t_e, t2_e, t3_e, h00, h01, h10, h11;

  assign rd_node = rdata_r[63:32];
  assign rd_val  = rdata_r[31:0];
  assign busy    = (state_r != S_IDLE);

  // effective node count
  always_comb begin
    if (count_r < 7'd2) n_eff = 7'd2;
    else if (count_r > 7'(MaxNodes)) n_eff = 7'(MaxNodes);
    else n_eff = count_r;
  end

  assign half  = len_r >> 1;
  assign mid   = first_r + half;
  assign idx_s = $signed({1'b0, first_r}) - 8'sd1;
  assign hi_ok = ({1'b0, idx_r} + 7'd2) < n_eff;

  // table memory: write on a write word, registered read every cycle
  always_ff @(posedge clk) begin
    if (start && !busy && in_command == CMD_WRITE) begin
      mem[in_entry_index] <= {in_node_position, in_node_value};
    end
    rdata_r <= mem[ra];
  end

  // read address per state
  always_comb begin
    unique case (state_r)
      S_HI:    ra = 6'(n_eff - 7'd1);
      S_BS:    ra = mid[5:0];
      S_R0:    ra = idx_r;
      S_R1:    ra = idx_r + 6'd1;
      S_R2:    ra = (idx_r != 6'd0) ? idx_r - 6'd1 : idx_r;
      S_R3:    ra = hi_ok ? idx_r + 6'd2 : idx_r + 6'd1;
      default: ra = 6'd0;
    endcase
  end

  // divider job select and operand magnitudes
  always_comb begin
    case (sel_r)
      DIV_SC0: begin
        dnum = 34'(x1_r) - 34'(x0_r);
        dden = 34'(x1_r) - 34'(xm_r);
        dact = (idx_r != 6'd0);
      end
      DIV_SC1: begin
        dnum = 34'(x1_r) - 34'(x0_r);
        dden = 34'(xp_r) - 34'(x0_r);
        dact = hi_ok;
      end
      default: begin
        dnum = 34'(x_r) - 34'(x0_r);
        dden = 34'(x1_r) - 34'(x0_r);
        dact = 1'b1;
      end
    endcase
    un = dnum[33] ? 34'(-dnum) : 34'(dnum);
    ud = dden[33] ? 34'(-dden) : 34'(dden);
  end

  assign rem2 = {rem_r[33:0], 1'b0};

  // Hermite basis from t, t^2, t^3
  always_comb begin
    t_e  = $signed({4'd0, t_r});
    t2_e = $signed({4'd0, t2_r});
    t3_e = $signed({4'd0, t3_r});
    h00  = 35'sd2 * t3_e - 35'sd3 * t2_e + (35'sd1 <<< Frac);
    h01  = 35'sd3 * t2_e - 35'sd2 * t3_e;
    h10  = t3_e - 35'sd2 * t2_e + t_e;
    h11  = t3_e - t2_e;
  end

  // multiplier operand select
  always_comb begin
    case (mstep_r)
      3'd0:    begin ma = 35'(f1_r) - 35'(fm_r); mb = $signed({4'd0, sc0_r}); end
      3'd1:    begin ma = 35'(fp_r) - 35'(f0_r); mb = $signed({4'd0, sc1_r}); end
      3'd2:    begin ma = t_e;  mb = t_e; end
      3'd3:    begin ma = t2_e; mb = t_e; end
      3'd4:    begin ma = h00;  mb = 35'(f0_r); end
      3'd5:    begin ma = h01;  mb = 35'(f1_r); end
      3'd6:    begin ma = h10;  mb = d0_r; end
      default: begin ma = h11;  mb = d1_r; end
    endcase
  end

  assign prod_sh = prod_r >>> Frac;
  assign acc_sh  = acc_r >>> Frac;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (start && in_command == CMD_EVAL) state_nxt = S_LO;
      S_LO:    state_nxt = S_HI;
      S_HI:    state_nxt = S_CHK;
      S_CHK:   state_nxt = (oor_r || x_r > rd_node) ? S_DONE : S_BS;
      S_BS:    state_nxt = (len_r == 7'd0) ? S_CLAMP : S_BSC;
      S_BSC:   state_nxt = S_BS;
      S_CLAMP: state_nxt = S_R0;
      S_R0:    state_nxt = S_R1;
      S_R1:    state_nxt = S_R2;
      S_R2:    state_nxt = S_R3;
      S_R3:    state_nxt = S_R4;
      S_R4:    state_nxt = S_DSET;
      S_DSET: begin
        if (dact && dden != 34'sd0 && dnum != 34'sd0 && dnum[33] == dden[33] && un < ud)
          state_nxt = S_DIT;
        else
          state_nxt = S_DEND;
      end
      S_DIT:   if (cnt_r == 5'd1) state_nxt = S_DEND;
      S_DEND: begin
        if (sel_r == DIV_T) state_nxt = bad_r ? S_DONE : S_MUL;
        else state_nxt = S_DSET;
      end
      S_MUL:   state_nxt = S_MACC;
      S_MACC:  state_nxt = (mstep_r == 3'd7) ? S_DONE : S_MUL;
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= 7'(MaxNodes);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == S_DONE);
      if (cfg_wr_en) count_r <= cfg_wr_data;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod_r <= ma * mb;
    case (state_r)
      S_IDLE: begin
        x_r   <= in_query_x;
        bad_r <= 1'b0;
        sel_r <= DIV_SC0;
      end
      S_HI:  oor_r <= (x_r < rd_node);
      S_CHK: begin
        stat_r  <= ST_RANGE;
        first_r <= 7'd0;
        len_r   <= n_eff;
      end
      S_BSC: begin
        if (rd_node <= x_r) begin
          first_r <= mid + 7'd1;
          len_r   <= len_r - half - 7'd1;
        end else begin
          len_r <= half;
        end
      end
      S_CLAMP: begin
        if (idx_s < 8'sd0) idx_r <= 6'd0;
        else if (idx_s > $signed({1'b0, n_eff}) - 8'sd2) idx_r <= 6'(n_eff - 7'd2);
        else idx_r <= idx_s[5:0];
      end
      S_R1: begin x0_r <= rd_node; f0_r <= rd_val; end
      S_R2: begin x1_r <= rd_node; f1_r <= rd_val; end
      S_R3: begin xm_r <= rd_node; fm_r <= rd_val; end
      S_R4: begin xp_r <= rd_node; fp_r <= rd_val; end
      S_DSET: begin
        rem_r <= {1'b0, un};
        ud_r  <= ud;
        cnt_r <= 5'(Frac);
        q_r   <= 31'd0;
        if (dact) begin
          if (dden == 34'sd0) bad_r <= 1'b1;
          else if (dnum != 34'sd0 && dnum[33] == dden[33] && un >= ud)
            q_r <= 31'd1 << Frac;
        end
      end
      // one quotient bit a cycle
      S_DIT: begin
        cnt_r <= cnt_r - 5'd1;
        if (rem2 >= {1'b0, ud_r}) begin
          rem_r <= rem2 - {1'b0, ud_r};
          q_r   <= {q_r[29:0], 1'b1};
        end else begin
          rem_r <= rem2;
          q_r   <= {q_r[29:0], 1'b0};
        end
      end
      S_DEND: begin
        case (sel_r)
          DIV_SC0: sc0_r <= q_r;
          DIV_SC1: sc1_r <= q_r;
          default: t_r   <= q_r;
        endcase
        sel_r   <= sel_r + 2'd1;
        mstep_r <= 3'd0;
        stat_r  <= bad_r ? ST_DEGEN : ST_OK;
      end
      // consume the registered product
      S_MACC: begin
        mstep_r <= mstep_r + 3'd1;
        case (mstep_r)
          3'd0: d0_r <= (idx_r != 6'd0) ? prod_sh[34:0] : 35'(f1_r) - 35'(f0_r);
          3'd1: d1_r <= hi_ok ? prod_sh[34:0] : 35'(f1_r) - 35'(f0_r);
          3'd2: t2_r <= prod_sh[30:0];
          3'd3: t3_r <= prod_sh[30:0];
          3'd4: acc_r <= 72'(prod_r);
          default: acc_r <= acc_r + 72'(prod_r);
        endcase
      end
      S_DONE: begin
        out_status_r <= stat_r;
        if (stat_r != ST_OK) out_result_r <= 32'sd0;
        else if (acc_sh > 72'sd2147483647) out_result_r <= 32'sh7fffffff;
        else if (acc_sh < -72'sd2147483648) out_result_r <= 32'sh80000000;
        else out_result_r <= acc_sh[31:0];
      end
      default: ;
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_result_r;
  assign out_status       = out_status_r;

`include "catmull_rom_spline_eval_assert.svh"

  `CRSE_ASSERT(a_strobe_idle, out_valid |-> !busy, "result word while still busy")
  `CRSE_ASSERT(a_eval_busy, (start && !busy && in_command == CMD_EVAL) |=> busy, "evaluate word not taken")
  `CRSE_ASSERT(a_status_code, out_valid |-> (out_status == ST_OK || out_status == ST_RANGE || out_status == ST_DEGEN), "bad status code")
  `CRSE_ASSERT(a_zero_on_fault, (out_valid && out_status != ST_OK) |-> out_result_value == 32'sd0, "nonzero result with fault status")
  `CRSE_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid, "strobe straight after reset")

endmodule
